// ----- hdl/drc_pkg.sv -----
// Shared widths, codes and reset values for the dirty rectangle coalescer.
// No dependencies; imported by the channel interfaces and the core.
`default_nettype none
package drc_pkg;
    localparam int COORD_W   = 14;
    localparam int SIZE_W    = 15;
    localparam int EDGE_W    = 15;
    localparam int IDX_OUT_W = 3;
    localparam int USED_W    = 4;
    localparam int THR_W     = 9;

    localparam logic [EDGE_W-1:0] EDGE_MAX  = 15'd16384;
    localparam logic [THR_W-1:0]  THR_RESET = 9'd135;
    localparam logic [6:0]        PCT_SCALE = 7'd100;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef logic [COORD_W-1:0]   t_coord;
    typedef logic [SIZE_W-1:0]    t_size;
    typedef logic [EDGE_W-1:0]    t_edge;
    typedef logic [IDX_OUT_W-1:0] t_idx_out;
    typedef logic [USED_W-1:0]    t_used;
    typedef logic [THR_W-1:0]     t_thr;
endpackage
`default_nettype wire

// ----- hdl/drc_in_if.sv -----
// Request channel of the coalescer: add or clear command with a rectangle.
// Depends on drc_pkg.
`default_nettype none
interface drc_in_if;
    import drc_pkg::*;
    logic   valid;
    logic   ready;
    logic   mode;
    t_coord rect_x;
    t_coord rect_y;
    t_size  rect_w;
    t_size  rect_h;

    modport source (output valid, mode, rect_x, rect_y, rect_w, rect_h, input ready);
    modport sink   (input valid, mode, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface
`default_nettype wire

// ----- hdl/drc_out_if.sv -----
// Result channel of the coalescer: slot written and its new edges.
// Depends on drc_pkg.
`default_nettype none
interface drc_out_if;
    import drc_pkg::*;
    logic     valid;
    logic     ready;
    t_idx_out slot_index;
    t_edge    slot_left;
    t_edge    slot_top;
    t_edge    slot_right;
    t_edge    slot_bottom;
    logic     merged_flag;
    logic     ignored_flag;
    t_used    slots_used;

    modport source (output valid, slot_index, slot_left, slot_top, slot_right,
                    slot_bottom, merged_flag, ignored_flag, slots_used,
                    input ready);
    modport sink   (input valid, slot_index, slot_left, slot_top, slot_right,
                    slot_bottom, merged_flag, ignored_flag, slots_used,
                    output ready);
endinterface
`default_nettype wire

// ----- hdl/drc_cfg_if.sv -----
// Configuration write channel of the coalescer: merge threshold in percent.
// Depends on drc_pkg.
`default_nettype none
interface drc_cfg_if;
    import drc_pkg::*;
    logic valid;
    logic ready;
    t_thr data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/dirty_rect_coalescer_core.sv -----
// Dirty rectangle coalescer core: slot table, scan sequencer, shared multiplier.
// Depends on drc_pkg, drc_in_if, drc_out_if, drc_cfg_if.
//
//  port    dir  modport  carries
//  i_req   in   sink     mode, rect_x, rect_y, rect_w, rect_h
//  o_res   out  source   slot_index, edges, merged/ignored flags, slots_used
//  i_cfg   in   sink     merge threshold (percent), always ready
//
// Add: per occupied slot a read, union and summed areas and two cross products on
// the shared multiplier, then two threshold-test products; an empty table skips both,
// as does a clear or empty add. One request at a time; i_req.ready only when idle.
// Result sits in an output register; a new request is taken while it waits.
// Reset: synchronous active low, empties the table, threshold back to 135.
`default_nettype none
module dirty_rect_coalescer_core #(
    parameter int SLOT_COUNT = 8
) (
    input  wire    i_clk,
    input  wire    i_rst_n,
    drc_in_if.sink    i_req,
    drc_out_if.source o_res,
    drc_cfg_if.sink   i_cfg
);
    import drc_pkg::*;

    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int AW = 2 * EDGE_W - 1;   // area, up to 2^28
    localparam int SW = 2 * EDGE_W;       // summed areas
    localparam int OW = 2 * SW;           // multiplier operand product

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ANEW = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_MU   = 4'd3;
    localparam logic [3:0] S_MS   = 4'd4;
    localparam logic [3:0] S_MC1  = 4'd5;
    localparam logic [3:0] S_MC2  = 4'd6;
    localparam logic [3:0] S_CMP  = 4'd7;
    localparam logic [3:0] S_DEC1 = 4'd8;
    localparam logic [3:0] S_DEC2 = 4'd9;
    localparam logic [3:0] S_DEC3 = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    logic [3:0]    r_state;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_idx;
    logic          r_ov;
    t_thr          r_thr;

    t_edge r_tl [SLOT_COUNT];
    t_edge r_tt [SLOT_COUNT];
    t_edge r_tr [SLOT_COUNT];
    t_edge r_tb [SLOT_COUNT];

    t_edge r_nl, r_nt, r_nr, r_nb, r_nw, r_nh;
    t_edge r_ul, r_ut, r_ur, r_ub, r_uw, r_uh, r_sw, r_sh;
    t_edge r_bl, r_bt, r_br, r_bb;
    logic [IW-1:0] r_bslot;
    logic [AW-1:0] r_anew, r_u, r_bu;
    logic [SW-1:0] r_s, r_bs;
    logic [OW-1:0] r_p1, r_p2;

    logic [IW-1:0] r_res_slot;
    t_edge         r_res_l, r_res_t, r_res_r, r_res_b;
    logic          r_res_merged, r_res_ignored;
    t_used         r_res_used;

    t_idx_out r_o_slot;
    t_edge    r_o_l, r_o_t, r_o_r, r_o_b;
    logic     r_o_merged, r_o_ignored;
    t_used    r_o_used;

    logic          w_acc, w_empty, w_load, w_take, w_merge, w_last;
    logic [EDGE_W:0] w_sum_r, w_sum_b;
    t_edge         w_r, w_b, w_sl, w_st, w_sr, w_sb, w_ul, w_ut, w_ur, w_ub;
    logic [SW-1:0] w_ma, w_mb;
    logic [OW-1:0] w_prod;
    logic [IW-1:0] w_wslot;

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_acc   = i_req.valid && i_req.ready;
    assign w_empty = (i_req.rect_w == '0) || (i_req.rect_h == '0);
    assign w_load  = (r_state == S_FIN) && (!r_ov || o_res.ready);
    assign w_take  = (r_idx == '0) || (r_p1 < r_p2);
    assign w_last  = (r_idx + 1'b1) == r_cnt;
    assign w_merge = (r_cnt != '0) && ((r_p1 < r_p2) || (r_cnt == CW'(SLOT_COUNT)));
    assign w_wslot = w_merge ? r_bslot : r_cnt[IW-1:0];

    // new rectangle edges, saturated
    assign w_sum_r = {2'b00, i_req.rect_x} + {1'b0, i_req.rect_w};
    assign w_sum_b = {2'b00, i_req.rect_y} + {1'b0, i_req.rect_h};
    assign w_r = (w_sum_r > {1'b0, EDGE_MAX}) ? EDGE_MAX : w_sum_r[EDGE_W-1:0];
    assign w_b = (w_sum_b > {1'b0, EDGE_MAX}) ? EDGE_MAX : w_sum_b[EDGE_W-1:0];

    // one slot read per scan step
    assign w_sl = r_tl[r_idx[IW-1:0]];
    assign w_st = r_tt[r_idx[IW-1:0]];
    assign w_sr = r_tr[r_idx[IW-1:0]];
    assign w_sb = r_tb[r_idx[IW-1:0]];
    assign w_ul = (w_sl < r_nl) ? w_sl : r_nl;
    assign w_ut = (w_st < r_nt) ? w_st : r_nt;
    assign w_ur = (w_sr > r_nr) ? w_sr : r_nr;
    assign w_ub = (w_sb > r_nb) ? w_sb : r_nb;

    // shared multiplier
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_ANEW: begin
                w_ma = SW'(r_nw);
                w_mb = SW'(r_nh);
            end
            S_MU: begin
                w_ma = SW'(r_uw);
                w_mb = SW'(r_uh);
            end
            S_MS: begin
                w_ma = SW'(r_sw);
                w_mb = SW'(r_sh);
            end
            S_MC1: begin
                w_ma = SW'(r_u);
                w_mb = r_bs;
            end
            S_MC2: begin
                w_ma = SW'(r_bu);
                w_mb = r_s;
            end
            S_DEC1: begin
                w_ma = SW'(r_bu);
                w_mb = SW'(PCT_SCALE);
            end
            S_DEC2: begin
                w_ma = SW'(r_thr);
                w_mb = r_bs;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_ov    <= 1'b0;
            r_thr   <= THR_RESET;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_thr <= i_cfg.data;
            end
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (i_req.mode == MODE_CLEAR) begin
                            r_cnt   <= '0;
                            r_state <= S_FIN;
                        end else if (w_empty) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_ANEW;
                        end
                    end
                end
                S_ANEW: begin
                    r_idx   <= '0;
                    r_state <= (r_cnt == '0) ? S_DEC3 : S_RD;
                end
                S_RD:   r_state <= S_MU;
                S_MU:   r_state <= S_MS;
                S_MS:   r_state <= S_MC1;
                S_MC1:  r_state <= S_MC2;
                S_MC2:  r_state <= S_CMP;
                S_CMP: begin
                    r_idx   <= r_idx + 1'b1;
                    r_state <= w_last ? S_DEC1 : S_RD;
                end
                S_DEC1: r_state <= S_DEC2;
                S_DEC2: r_state <= S_DEC3;
                S_DEC3: begin
                    if (!w_merge) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath and slot table
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    r_nl <= {1'b0, i_req.rect_x};
                    r_nt <= {1'b0, i_req.rect_y};
                    r_nr <= w_r;
                    r_nb <= w_b;
                    r_nw <= w_r - {1'b0, i_req.rect_x};
                    r_nh <= w_b - {1'b0, i_req.rect_y};
                    r_res_slot    <= '0;
                    r_res_l       <= '0;
                    r_res_t       <= '0;
                    r_res_r       <= '0;
                    r_res_b       <= '0;
                    r_res_merged  <= 1'b0;
                    r_res_ignored <= 1'b1;
                    r_res_used    <= (i_req.mode == MODE_CLEAR) ? '0 : USED_W'(r_cnt);
                end
            end
            S_ANEW: r_anew <= AW'(w_prod);
            S_RD: begin
                r_ul <= w_ul;
                r_ut <= w_ut;
                r_ur <= w_ur;
                r_ub <= w_ub;
                r_uw <= w_ur - w_ul;
                r_uh <= w_ub - w_ut;
                r_sw <= w_sr - w_sl;
                r_sh <= w_sb - w_st;
            end
            S_MU:  r_u  <= AW'(w_prod);
            S_MS:  r_s  <= SW'(w_prod) + SW'(r_anew);
            S_MC1: r_p1 <= w_prod;
            S_MC2: r_p2 <= w_prod;
            S_CMP: begin
                if (w_take) begin
                    r_bu    <= r_u;
                    r_bs    <= r_s;
                    r_bslot <= r_idx[IW-1:0];
                    r_bl    <= r_ul;
                    r_bt    <= r_ut;
                    r_br    <= r_ur;
                    r_bb    <= r_ub;
                end
            end
            S_DEC1: r_p1 <= w_prod;
            S_DEC2: r_p2 <= w_prod;
            S_DEC3: begin
                r_res_slot    <= w_wslot;
                r_res_merged  <= w_merge;
                r_res_ignored <= 1'b0;
                if (w_merge) begin
                    r_tl[w_wslot] <= r_bl;
                    r_tt[w_wslot] <= r_bt;
                    r_tr[w_wslot] <= r_br;
                    r_tb[w_wslot] <= r_bb;
                    r_res_l       <= r_bl;
                    r_res_t       <= r_bt;
                    r_res_r       <= r_br;
                    r_res_b       <= r_bb;
                    r_res_used    <= USED_W'(r_cnt);
                end else begin
                    r_tl[w_wslot] <= r_nl;
                    r_tt[w_wslot] <= r_nt;
                    r_tr[w_wslot] <= r_nr;
                    r_tb[w_wslot] <= r_nb;
                    r_res_l       <= r_nl;
                    r_res_t       <= r_nt;
                    r_res_r       <= r_nr;
                    r_res_b       <= r_nb;
                    r_res_used    <= USED_W'(CW'(r_cnt + 1'b1));
                end
            end
            default: ;
        endcase
        if (w_load) begin
            r_o_slot    <= IDX_OUT_W'(r_res_slot);
            r_o_l       <= r_res_l;
            r_o_t       <= r_res_t;
            r_o_r       <= r_res_r;
            r_o_b       <= r_res_b;
            r_o_merged  <= r_res_merged;
            r_o_ignored <= r_res_ignored;
            r_o_used    <= r_res_used;
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.slot_index   = r_o_slot;
    assign o_res.slot_left    = r_o_l;
    assign o_res.slot_top     = r_o_t;
    assign o_res.slot_right   = r_o_r;
    assign o_res.slot_bottom  = r_o_b;
    assign o_res.merged_flag  = r_o_merged;
    assign o_res.ignored_flag = r_o_ignored;
    assign o_res.slots_used   = r_o_used;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(SLOT_COUNT))
        else $error("slot count above table size");

    a_full_merges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC3 && r_cnt == CW'(SLOT_COUNT)) |=> r_res_merged)
        else $error("full table did not merge");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_idx < r_cnt))
        else $error("scan index past occupied slots");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_req.mode == MODE_CLEAR) |=> (r_cnt == '0 && r_state == S_FIN))
        else $error("clear did not empty table");
endmodule
`default_nettype wire

// ----- sim/tb_dirty_rect_coalescer_core.sv -----
// Testbench for dirty_rect_coalescer_core: directed table then random add/clear requests,
// checked against typed rows or an in-bench slot table model, under several merge thresholds.
// Depends on drc_pkg, drc_in_if, drc_out_if, drc_cfg_if and the core.
`default_nettype none
module tb_dirty_rect_coalescer_core;
    timeunit 1ns;
    timeprecision 1ps;
    import drc_pkg::*;

    localparam int SLOTS       = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 60;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 225;
    localparam bit TYPED       = 1'b1;
    localparam bit OPEN        = 1'b0;

    typedef struct packed {
        t_idx_out slot;
        t_edge    left;
        t_edge    top;
        t_edge    right;
        t_edge    bottom;
        logic     merged;
        logic     ignored;
        t_used    used;
    } t_slot_update;

    typedef struct packed {
        logic         mode;
        t_coord       x;
        t_coord       y;
        t_size        w;
        t_size        h;
        logic         typed;
        t_slot_update exp;
    } t_rect_cmd;

    logic i_clk;
    logic i_rst_n;

    drc_in_if  req_if ();
    drc_out_if res_if ();
    drc_cfg_if cfg_if ();

    dirty_rect_coalescer_core #(.SLOT_COUNT(SLOTS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // slot table model
    t_edge slot_l [SLOTS];
    t_edge slot_t [SLOTS];
    t_edge slot_r [SLOTS];
    t_edge slot_b [SLOTS];
    t_used used_model = '0;
    t_thr  thr_model  = THR_RESET;

    t_slot_update pending_updates[$];
    t_rect_cmd    directed_rows[$];
    logic         drv_typed;
    t_slot_update drv_exp;

    int mismatches = 0;
    int n_new      = 0;
    int n_merged   = 0;
    int n_ignored  = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_asks   = 0;
    int hold_taken  = 0;
    int hold_left   = 0;
    int unsigned hot_x = 0;
    int unsigned hot_y = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    function automatic int unsigned lo(int unsigned a, int unsigned b);
        return (a < b) ? a : b;
    endfunction

    function automatic int unsigned hi(int unsigned a, int unsigned b);
        return (a > b) ? a : b;
    endfunction

    function automatic longint unsigned rect_area(int unsigned l, int unsigned t,
                                                  int unsigned r, int unsigned b);
        longint unsigned wd;
        longint unsigned ht;
        wd = (r > l) ? 64'(r - l) : 64'(0);
        ht = (b > t) ? 64'(b - t) : 64'(0);
        return wd * ht;
    endfunction

    function automatic t_slot_update coalesce_rect(logic mode, t_coord x, t_coord y,
                                                   t_size w, t_size h);
        t_slot_update upd;
        int unsigned xe, ye, rgt, bot, n, best;
        longint unsigned a_new, u, s, best_u, best_s;
        bit have_best, merge;
        upd = '0;
        if (mode == MODE_CLEAR) begin
            used_model  = '0;
            upd.ignored = 1'b1;
            return upd;
        end
        if (w == 0 || h == 0) begin
            upd.ignored = 1'b1;
            upd.used    = used_model;
            return upd;
        end
        xe  = 32'(x);
        ye  = 32'(y);
        rgt = lo(xe + 32'(w), 32'(EDGE_MAX));
        bot = lo(ye + 32'(h), 32'(EDGE_MAX));
        a_new = rect_area(xe, ye, rgt, bot);
        n = 32'(used_model);
        best = 0;
        have_best = 1'b0;
        best_u = 0;
        best_s = 1;
        for (int i = 0; i < n; i++) begin
            u = rect_area(lo(32'(slot_l[i]), xe), lo(32'(slot_t[i]), ye),
                          hi(32'(slot_r[i]), rgt), hi(32'(slot_b[i]), bot));
            s = rect_area(32'(slot_l[i]), 32'(slot_t[i]), 32'(slot_r[i]),
                          32'(slot_b[i])) + a_new;
            // strict compare: lowest slot keeps a tie
            if (!have_best || u * best_s < best_u * s) begin
                have_best = 1'b1;
                best_u = u;
                best_s = s;
                best = i;
            end
        end
        merge = have_best && (best_u * PCT_SCALE < longint'(thr_model) * best_s || n >= SLOTS);
        if (merge) begin
            slot_l[best] = t_edge'(lo(32'(slot_l[best]), xe));
            slot_t[best] = t_edge'(lo(32'(slot_t[best]), ye));
            slot_r[best] = t_edge'(hi(32'(slot_r[best]), rgt));
            slot_b[best] = t_edge'(hi(32'(slot_b[best]), bot));
        end else begin
            best = n;
            slot_l[best] = t_edge'(xe);
            slot_t[best] = t_edge'(ye);
            slot_r[best] = t_edge'(rgt);
            slot_b[best] = t_edge'(bot);
            used_model = t_used'(n + 1);
        end
        upd.slot   = t_idx_out'(best);
        upd.left   = slot_l[best];
        upd.top    = slot_t[best];
        upd.right  = slot_r[best];
        upd.bottom = slot_b[best];
        upd.merged = merge;
        upd.used   = used_model;
        return upd;
    endfunction

    function automatic t_rect_cmd mk_row(logic mode, int unsigned x, int unsigned y,
                                         int unsigned w, int unsigned h, bit typed,
                                         int unsigned slot, int unsigned l, int unsigned t,
                                         int unsigned r, int unsigned b, int unsigned merged,
                                         int unsigned ignored, int unsigned used);
        t_rect_cmd cmd;
        cmd = '0;
        cmd.mode = mode;
        cmd.x = t_coord'(x);
        cmd.y = t_coord'(y);
        cmd.w = t_size'(w);
        cmd.h = t_size'(h);
        cmd.typed = typed;
        cmd.exp.slot = t_idx_out'(slot);
        cmd.exp.left = t_edge'(l);
        cmd.exp.top = t_edge'(t);
        cmd.exp.right = t_edge'(r);
        cmd.exp.bottom = t_edge'(b);
        cmd.exp.merged = 1'(merged);
        cmd.exp.ignored = 1'(ignored);
        cmd.exp.used = t_used'(used);
        return cmd;
    endfunction

    // mostly clustered small adds so merges happen; some clears, empties, huge and edge rects
    function automatic t_rect_cmd random_rect();
        t_rect_cmd cmd;
        int unsigned pick;
        pick = $urandom_range(99);
        cmd = '0;
        cmd.mode = MODE_ADD;
        cmd.x = t_coord'($urandom_range(16383));
        cmd.y = t_coord'($urandom_range(16383));
        cmd.w = t_size'($urandom_range(1, 64));
        cmd.h = t_size'($urandom_range(1, 64));
        if (pick < 3) begin
            cmd.mode = MODE_CLEAR;
            cmd.w = t_size'($urandom_range(16384));
            cmd.h = t_size'($urandom_range(16384));
            hot_x = $urandom_range(16000);
            hot_y = $urandom_range(16000);
        end else if (pick < 7) begin
            if ($urandom_range(1)) begin
                cmd.w = '0;
                cmd.h = t_size'($urandom_range(16384));
            end else begin
                cmd.h = '0;
                cmd.w = t_size'($urandom_range(16384));
            end
        end else if (pick < 57) begin
            cmd.x = t_coord'(hot_x + $urandom_range(240));
            cmd.y = t_coord'(hot_y + $urandom_range(240));
            cmd.w = t_size'($urandom_range(1, 160));
            cmd.h = t_size'($urandom_range(1, 160));
        end else if (pick < 80) begin
            if ($urandom_range(4) == 0) begin
                hot_x = $urandom_range(16000);
                hot_y = $urandom_range(16000);
            end
        end else if (pick < 92) begin
            cmd.w = t_size'($urandom_range(1, 2048));
            cmd.h = t_size'($urandom_range(1, 2048));
        end else if (pick < 97) begin
            cmd.w = $urandom_range(1) ? EDGE_MAX : t_size'($urandom_range(1, 16384));
            cmd.h = $urandom_range(1) ? EDGE_MAX : t_size'($urandom_range(1, 16384));
        end else begin
            cmd.x = t_coord'(16383 - $urandom_range(31));
            cmd.y = t_coord'(16383 - $urandom_range(31));
            cmd.w = t_size'($urandom_range(1, 96));
            cmd.h = t_size'($urandom_range(1, 96));
        end
        return cmd;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic offer_rect(input t_rect_cmd cmd);
        if ($urandom_range(99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        req_if.valid  <= 1'b1;
        req_if.mode   <= cmd.mode;
        req_if.rect_x <= cmd.x;
        req_if.rect_y <= cmd.y;
        req_if.rect_w <= cmd.w;
        req_if.rect_h <= cmd.h;
        drv_typed     <= cmd.typed;
        drv_exp       <= cmd.exp;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic drain_requests();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_threshold(input t_thr value);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    // receiver: random stalls plus one long hold-off, asked for in the third random phase
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && hold_asks != hold_taken) begin
                hold_taken++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_slot_update want;
        t_slot_update upd;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready)
                thr_model = cfg_if.data;
            if (req_if.valid && req_if.ready) begin
                upd = coalesce_rect(req_if.mode, req_if.rect_x, req_if.rect_y,
                                    req_if.rect_w, req_if.rect_h);
                pending_updates.push_back(drv_typed ? drv_exp : upd);
            end
            if (res_if.valid && res_if.ready) begin
                if (pending_updates.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatches++;
                end else begin
                    want = pending_updates.pop_front();
                    check_field("slot_index", 32'(want.slot), 32'(res_if.slot_index));
                    check_field("slot_left", 32'(want.left), 32'(res_if.slot_left));
                    check_field("slot_top", 32'(want.top), 32'(res_if.slot_top));
                    check_field("slot_right", 32'(want.right), 32'(res_if.slot_right));
                    check_field("slot_bottom", 32'(want.bottom), 32'(res_if.slot_bottom));
                    check_field("merged_flag", 32'(want.merged), 32'(res_if.merged_flag));
                    check_field("ignored_flag", 32'(want.ignored), 32'(res_if.ignored_flag));
                    check_field("slots_used", 32'(want.used), 32'(res_if.slots_used));
                    if (want.ignored)
                        n_ignored++;
                    else if (want.merged)
                        n_merged++;
                    else
                        n_new++;
                end
            end
        end
    end

    initial begin
        t_thr phase_thr [RAND_PHASES];
        i_rst_n       <= 1'b0;
        req_if.valid  <= 1'b0;
        req_if.mode   <= MODE_ADD;
        req_if.rect_x <= '0;
        req_if.rect_y <= '0;
        req_if.rect_w <= '0;
        req_if.rect_h <= '0;
        cfg_if.valid  <= 1'b0;
        cfg_if.data   <= '0;
        drv_typed     <= 1'b0;
        drv_exp       <= '0;
        phase_thr = '{9'd0, 9'd511, 9'd100, 9'd400, t_thr'($urandom_range(100, 400)), THR_RESET};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 18;
        rx_idle_pct = 65;
        // empty adds, full-screen and saturating edges, clears, tie goes to the lower slot
        directed_rows.push_back(mk_row(MODE_ADD, 0, 0, 0, 5, TYPED, 0, 0, 0, 0, 0, 0, 1, 0));
        directed_rows.push_back(mk_row(MODE_ADD, 16383, 16383, 16384, 0, TYPED,
                                       0, 0, 0, 0, 0, 0, 1, 0));
        directed_rows.push_back(mk_row(MODE_ADD, 0, 0, 16384, 16384, TYPED,
                                       0, 0, 0, 16384, 16384, 0, 0, 1));
        directed_rows.push_back(mk_row(MODE_ADD, 16383, 16383, 16384, 16384, TYPED,
                                       0, 0, 0, 16384, 16384, 1, 0, 1));
        directed_rows.push_back(mk_row(MODE_CLEAR, 16383, 16383, 16384, 16384, TYPED,
                                       0, 0, 0, 0, 0, 0, 1, 0));
        directed_rows.push_back(mk_row(MODE_ADD, 0, 0, 1, 1, TYPED, 0, 0, 0, 1, 1, 0, 0, 1));
        directed_rows.push_back(mk_row(MODE_ADD, 1000, 1000, 1, 1, TYPED,
                                       1, 1000, 1000, 1001, 1001, 0, 0, 2));
        directed_rows.push_back(mk_row(MODE_ADD, 0, 0, 1, 1, TYPED, 0, 0, 0, 1, 1, 1, 0, 2));
        directed_rows.push_back(mk_row(MODE_ADD, 1, 0, 1, 1, TYPED, 0, 0, 0, 2, 1, 1, 0, 2));
        directed_rows.push_back(mk_row(MODE_CLEAR, 0, 0, 0, 0, TYPED, 0, 0, 0, 0, 0, 0, 1, 0));
        directed_rows.push_back(mk_row(MODE_ADD, 0, 0, 10, 10, TYPED,
                                       0, 0, 0, 10, 10, 0, 0, 1));
        directed_rows.push_back(mk_row(MODE_ADD, 20, 0, 10, 10, TYPED,
                                       1, 20, 0, 30, 10, 0, 0, 2));
        directed_rows.push_back(mk_row(MODE_ADD, 10, 0, 10, 10, TYPED,
                                       0, 0, 0, 20, 10, 1, 0, 2));
        directed_rows.push_back(mk_row(MODE_CLEAR, 5, 5, 5, 5, TYPED, 0, 0, 0, 0, 0, 0, 1, 0));
        for (int k = 0; k < SLOTS; k++)
            directed_rows.push_back(mk_row(MODE_ADD, k * 2000, 0, 1, 1, OPEN,
                                           0, 0, 0, 0, 0, 0, 0, 0));
        // table full: forced merges, empty add reports eight slots
        directed_rows.push_back(mk_row(MODE_ADD, 16383, 16383, 1, 1, OPEN,
                                       0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(MODE_ADD, 5, 5, 0, 0, TYPED, 0, 0, 0, 0, 0, 0, 1, 8));
        directed_rows.push_back(mk_row(MODE_ADD, 0, 0, 16384, 16384, OPEN,
                                       0, 0, 0, 0, 0, 0, 0, 0));
        foreach (directed_rows[i])
            offer_rect(directed_rows[i]);
        drain_requests();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph / 2)
                0: begin
                    tx_idle_pct = 18;
                    rx_idle_pct = 65;
                end
                1: begin
                    tx_idle_pct = 65;
                    rx_idle_pct = 18;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            write_threshold(phase_thr[ph]);
            if (ph == 2)
                hold_asks++;
            repeat (PHASE_ITEMS) offer_rect(random_rect());
            drain_requests();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d requests: %0d new slots, %0d merges, %0d clears or empty adds",
                 n_new + n_merged + n_ignored, n_new, n_merged, n_ignored);
        $display("thresholds 135, 0, 511, 100, 400, %0d, 135; one %0d-cycle receiver hold-off",
                 phase_thr[4], HOLD_CYCLES);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
